// ===== hdl/edg_pkg.sv =====
// types and constants shared by the elevator group dispatcher
// no dependencies
package edg_pkg;

    localparam logic [1:0] REQ_HALL = 2'd0;
    localparam logic [1:0] REQ_CAR  = 2'd1;
    localparam logic [1:0] REQ_TICK = 2'd2;

    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_BAD_FLOOR = 2'd1;
    localparam logic [1:0] ST_BAD_CAR   = 2'd2;
    localparam logic [1:0] ST_FULL      = 2'd3;

    localparam logic [1:0] HEAD_UP   = 2'd0;
    localparam logic [1:0] HEAD_DOWN = 2'd1;
    localparam logic [1:0] HEAD_IDLE = 2'd2;

    localparam logic [5:0] TOP_FLOOR_RESET = 6'd20;
    localparam logic [15:0] DIST_MAX = 16'hffff;

    // per-car record held in the car state memory
    typedef struct packed {
        logic [5:0]  pos;
        logic [1:0]  heading;
        logic [5:0]  head;
        logic [6:0]  count;
        logic [15:0] travel;
    } car_rec_t;

    typedef struct packed {
        logic [1:0] status;
        logic [3:0] car;
        car_rec_t   rec;
        logic       arrived;
        logic       last;
    } result_t;

    function automatic logic [5:0] start_floor(input logic [2:0] idx);
        logic [5:0] f;
        unique case (idx)
            3'd1:    f = 6'd2;
            3'd2:    f = 6'd8;
            3'd3:    f = 6'd16;
            default: f = 6'd0;
        endcase
        return f;
    endfunction

endpackage

// ===== hdl/edg_car_mem.sv =====
// per-car state memory, one record per car, registered read
// valid bits make never-written entries read as their reset record; uses edg_pkg
module edg_car_mem #(
    parameter int NUM_CARS = 4,
    parameter int CIW = 2
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic [CIW-1:0]    raddr,
    output edg_pkg::car_rec_t rdata,
    input  logic              we,
    input  logic [CIW-1:0]    waddr,
    input  edg_pkg::car_rec_t wdata
);
    import edg_pkg::*;

    car_rec_t mem [NUM_CARS];
    logic [NUM_CARS-1:0] valid_reg;
    car_rec_t rdata_reg;
    car_rec_t rst_rec;

    always_comb
    begin
        rst_rec = '0;
        rst_rec.pos = start_floor(3'(raddr));
        rst_rec.heading = HEAD_IDLE;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else if (we)
        begin
            valid_reg[waddr] <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= valid_reg[raddr] ? mem[raddr] : rst_rec;
    end

    assign rdata = rdata_reg;

endmodule

// ===== hdl/edg_fifo_mem.sv =====
// destination queues of all cars in one memory, addressed {car, slot}
// registered read; no dependencies
module edg_fifo_mem #(
    parameter int AW = 5
) (
    input  logic          clk,
    input  logic [AW-1:0] raddr,
    output logic [5:0]    rdata,
    input  logic          we,
    input  logic [AW-1:0] waddr,
    input  logic [5:0]    wdata
);
    logic [5:0] mem [2**AW];
    logic [5:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ===== hdl/elevator_group_dispatcher.sv =====
// elevator group dispatcher: sequencer around the car state and queue memories
// uses edg_pkg, edg_car_mem, edg_fifo_mem
//
// Input channel (in_valid/in_stall) takes one request: hall call, car call or
// tick. Output channel (out_valid/out_stall) gives one result per call and
// NUM_CARS results per tick, the final one marked by last. in_stall is high
// while a request is in work; one request is handled at a time.
// Sequence of states, paced by the registered read of the car state memory:
//   hall call: IDLE, SCAN (one car record read per cycle for scoring), APPEND, EMIT
//   car call: IDLE, CWAIT, APPEND, EMIT; car call to an invalid floor: IDLE, CWAIT, EMIT
//   invalid hall floor or invalid car: IDLE, EMIT
//   tick: per car, record read, queue head read (TREC), update (TCALC), then EMIT
// A result sits in the output register until taken; while one is held and out_stall
// is high, the sequencer waits and the result holds. Code 3 requests give no result.
// Reset: cars at floors 0, 2, 8, 16 (others 0), idle, empty queues, top_floor
// 20. The queue memory is not cleared; only written entries are ever used. APB holds
// top_floor at addresses 0-3; the user must write it while idle only, it is not enforced.
module elevator_group_dispatcher #(
    parameter int NUM_CARS = 4,
    parameter int QUEUE_DEPTH = 8
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [1:0]  req_type,
    input  logic [5:0]  floor,
    input  logic [2:0]  car_number,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [1:0]  status,
    output logic [3:0]  car_index,
    output logic [5:0]  car_floor_now,
    output logic [1:0]  heading,
    output logic [6:0]  pending,
    output logic        arrived,
    output logic [15:0] travelled,
    output logic        last,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import edg_pkg::*;

    localparam int CIW = (NUM_CARS > 1) ? $clog2(NUM_CARS) : 1;
    localparam int HW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int FAW = CIW + HW;
    localparam logic [6:0] QD = 7'(QUEUE_DEPTH);
    localparam logic [CIW-1:0] LAST_CAR = CIW'(NUM_CARS - 1);

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_SCAN   = 3'd1;
    localparam logic [2:0] S_CWAIT  = 3'd2;
    localparam logic [2:0] S_APPEND = 3'd3;
    localparam logic [2:0] S_TREC   = 3'd4;
    localparam logic [2:0] S_TCALC  = 3'd5;
    localparam logic [2:0] S_EMIT   = 3'd6;

    logic [2:0]     state_reg, state_next;
    logic [1:0]     type_reg, type_next;
    logic [5:0]     floor_reg, floor_next;
    logic [CIW-1:0] cnt_reg, cnt_next;
    logic [CIW-1:0] best_reg, best_next;
    logic [9:0]     best_s_reg, best_s_next;
    car_rec_t       best_rec_reg, best_rec_next;
    car_rec_t       rec_reg, rec_next;
    result_t        res_reg, res_next;
    logic [5:0]     top_reg;

    result_t out_reg;
    logic    out_valid_reg;
    logic    out_free;

    logic [CIW-1:0] car_raddr;
    car_rec_t       car_rdata;
    logic           car_we;
    logic [CIW-1:0] car_waddr;
    car_rec_t       car_wdata;
    logic [FAW-1:0] fifo_raddr;
    logic [5:0]     fifo_rdata;
    logic           fifo_we;
    logic [FAW-1:0] fifo_waddr;

    logic       accept;
    logic [5:0] dist_f;
    logic [9:0] score;
    logic [7:0] slot_sum;
    logic [7:0] slot;
    car_rec_t   tick_rec;
    logic       tick_arr;

    assign pready = 1'b1;
    assign prdata = (paddr[2] == 1'b0) ? {26'd0, top_reg} : 32'd0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            top_reg <= TOP_FLOOR_RESET;
        end
        else if (psel && penable && pwrite && paddr[2] == 1'b0)
        begin
            top_reg <= pwdata[5:0];
        end
    end

    edg_car_mem #(.NUM_CARS(NUM_CARS), .CIW(CIW)) u_car_mem (
        .clk   (clk),
        .rst_n (rst_n),
        .raddr (car_raddr),
        .rdata (car_rdata),
        .we    (car_we),
        .waddr (car_waddr),
        .wdata (car_wdata)
    );

    edg_fifo_mem #(.AW(FAW)) u_fifo_mem (
        .clk   (clk),
        .raddr (fifo_raddr),
        .rdata (fifo_rdata),
        .we    (fifo_we),
        .waddr (fifo_waddr),
        .wdata (floor_reg)
    );

    assign in_stall = (state_reg != S_IDLE);
    assign accept = in_valid && !in_stall;
    assign out_free = !out_valid_reg || !out_stall;

    // score of the car whose record is on the read port
    always_comb
    begin
        dist_f = (car_rdata.pos > floor_reg) ? car_rdata.pos - floor_reg
                                             : floor_reg - car_rdata.pos;
        score = {1'b0, dist_f, 3'd0} + {3'd0, dist_f, 1'b0} + {3'd0, car_rdata.count}
                + ((car_rdata.heading != HEAD_IDLE) ? 10'd2 : 10'd0);
    end

    // tail slot of the chosen car, head + count taken modulo the depth
    always_comb
    begin
        slot_sum = {2'b0, best_rec_reg.head} + {1'b0, best_rec_reg.count};
        slot = (slot_sum >= {1'b0, QD}) ? slot_sum - {1'b0, QD} : slot_sum;
    end

    // one floor of travel toward the head destination
    always_comb
    begin
        tick_rec = rec_reg;
        tick_arr = 1'b0;
        if (rec_reg.count == 7'd0)
        begin
            tick_rec.heading = HEAD_IDLE;
        end
        else
        begin
            if (rec_reg.pos < fifo_rdata)
            begin
                tick_rec.pos = rec_reg.pos + 6'd1;
                tick_rec.heading = HEAD_UP;
                if (rec_reg.travel != DIST_MAX)
                begin
                    tick_rec.travel = rec_reg.travel + 16'd1;
                end
            end
            else if (rec_reg.pos > fifo_rdata)
            begin
                tick_rec.pos = rec_reg.pos - 6'd1;
                tick_rec.heading = HEAD_DOWN;
                if (rec_reg.travel != DIST_MAX)
                begin
                    tick_rec.travel = rec_reg.travel + 16'd1;
                end
            end
            if (tick_rec.pos == fifo_rdata)
            begin
                tick_arr = 1'b1;
                tick_rec.head = (rec_reg.head == 6'(QUEUE_DEPTH - 1)) ? 6'd0
                                                                       : rec_reg.head + 6'd1;
                tick_rec.count = rec_reg.count - 7'd1;
                if (tick_rec.count == 7'd0)
                begin
                    tick_rec.heading = HEAD_IDLE;
                end
            end
        end
    end

    always_comb
    begin
        state_next = state_reg;
        type_next = type_reg;
        floor_next = floor_reg;
        cnt_next = cnt_reg;
        best_next = best_reg;
        best_s_next = best_s_reg;
        best_rec_next = best_rec_reg;
        rec_next = rec_reg;
        res_next = res_reg;
        car_raddr = cnt_reg;
        car_we = 1'b0;
        car_waddr = best_reg;
        car_wdata = best_rec_reg;
        fifo_raddr = {cnt_reg, car_rdata.head[HW-1:0]};
        fifo_we = 1'b0;
        fifo_waddr = {best_reg, slot[HW-1:0]};

        unique case (state_reg)
            S_IDLE:
            begin
                car_raddr = '0;
                if (accept)
                begin
                    type_next = req_type;
                    floor_next = floor;
                    cnt_next = '0;
                    res_next = '0;
                    res_next.last = 1'b1;
                    priority if (req_type == REQ_HALL)
                    begin
                        if (floor > top_reg)
                        begin
                            res_next.status = ST_BAD_FLOOR;
                            state_next = S_EMIT;
                        end
                        else
                        begin
                            state_next = S_SCAN;
                        end
                    end
                    else if (req_type == REQ_CAR)
                    begin
                        if (car_number == 3'd0 || {1'b0, car_number} > 4'(NUM_CARS))
                        begin
                            res_next.status = ST_BAD_CAR;
                            state_next = S_EMIT;
                        end
                        else
                        begin
                            car_raddr = CIW'(car_number - 3'd1);
                            best_next = CIW'(car_number - 3'd1);
                            state_next = S_CWAIT;
                        end
                    end
                    else if (req_type == REQ_TICK)
                    begin
                        state_next = S_TREC;
                    end
                    else
                    begin
                        state_next = S_IDLE;
                    end
                end
            end
            S_SCAN:
            begin
                // record of car cnt_reg arrives while the next one is read
                car_raddr = CIW'(cnt_reg + 1'b1);
                if (cnt_reg == '0 || score < best_s_reg)
                begin
                    best_next = cnt_reg;
                    best_s_next = score;
                    best_rec_next = car_rdata;
                end
                if (cnt_reg == LAST_CAR)
                begin
                    state_next = S_APPEND;
                end
                else
                begin
                    cnt_next = CIW'(cnt_reg + 1'b1);
                end
            end
            S_CWAIT:
            begin
                best_rec_next = car_rdata;
                if (floor_reg == 6'd0 || floor_reg > top_reg)
                begin
                    res_next.status = ST_BAD_FLOOR;
                    res_next.car = 4'(best_reg) + 4'd1;
                    res_next.rec = car_rdata;
                    state_next = S_EMIT;
                end
                else
                begin
                    state_next = S_APPEND;
                end
            end
            S_APPEND:
            begin
                res_next.car = 4'(best_reg) + 4'd1;
                if (best_rec_reg.count >= QD)
                begin
                    res_next.status = ST_FULL;
                    res_next.rec = best_rec_reg;
                end
                else
                begin
                    fifo_we = 1'b1;
                    car_we = 1'b1;
                    car_wdata.count = best_rec_reg.count + 7'd1;
                    res_next.status = ST_OK;
                    res_next.rec = car_wdata;
                end
                state_next = S_EMIT;
            end
            S_TREC:
            begin
                rec_next = car_rdata;
                state_next = S_TCALC;
            end
            S_TCALC:
            begin
                car_we = 1'b1;
                car_waddr = cnt_reg;
                car_wdata = tick_rec;
                res_next.status = ST_OK;
                res_next.car = 4'(cnt_reg) + 4'd1;
                res_next.rec = tick_rec;
                res_next.arrived = tick_arr;
                res_next.last = (cnt_reg == LAST_CAR);
                state_next = S_EMIT;
            end
            S_EMIT:
            begin
                car_raddr = CIW'(cnt_reg + 1'b1);
                if (out_free)
                begin
                    if (type_reg == REQ_TICK && cnt_reg != LAST_CAR)
                    begin
                        cnt_next = CIW'(cnt_reg + 1'b1);
                        state_next = S_TREC;
                    end
                    else
                    begin
                        state_next = S_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == S_EMIT && out_free)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        type_reg <= type_next;
        floor_reg <= floor_next;
        cnt_reg <= cnt_next;
        best_reg <= best_next;
        best_s_reg <= best_s_next;
        best_rec_reg <= best_rec_next;
        rec_reg <= rec_next;
        res_reg <= res_next;
        if (state_reg == S_EMIT && out_free)
        begin
            out_reg <= res_reg;
        end
    end

    assign out_valid = out_valid_reg;
    assign status = out_reg.status;
    assign car_index = out_reg.car;
    assign car_floor_now = out_reg.rec.pos;
    assign heading = out_reg.rec.heading;
    assign pending = out_reg.rec.count;
    assign arrived = out_reg.arrived;
    assign travelled = out_reg.rec.travel;
    assign last = out_reg.last;

    // no state write-back in the idle and emit states
    a_no_write_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_IDLE || state_reg == S_EMIT) |-> !car_we && !fifo_we)
        else $error("state memory written while not updating");

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        car_we |-> car_wdata.count <= QD)
        else $error("queue count beyond depth");

    a_append_room: assert property (@(posedge clk) disable iff (!rst_n)
        fifo_we |-> best_rec_reg.count < QD && car_we)
        else $error("queue append without room or without count update");

    a_result_held: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_EMIT && !out_free) |=> state_reg == S_EMIT)
        else $error("sequencer left emit while output was blocked");

endmodule
